>>> hdl/buffer_pool_page_replacement_defines.svh
// Assertion macros shared by the buffer pool replacement RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_DEFINES_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bppr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bppr assertion failed");

`endif

>>> hdl/bppr_pkg.sv
// Package of the buffer pool replacement block: sizes, codes and frame types.
// No dependencies; the frame table, the top level and the testbench import it.
`timescale 1ns / 1ps
package bppr_pkg;
	localparam int FRAMES      = 16;
	localparam int PAGE_BITS   = 31;
	localparam int IDX_W       = $clog2(FRAMES);
	localparam int N_W         = $clog2(FRAMES + 1);
	localparam int CNT_W       = N_W + 1;
	localparam int PIN_W       = 16;
	localparam int STAMP_W     = 32;
	localparam int TOTAL_W     = 32;
	localparam int PAGE_OUT_W  = 31;
	localparam int FRAME_OUT_W = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

	localparam logic [1:0] POL_FIFO  = 2'd0;
	localparam logic [1:0] POL_LRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;

	localparam logic [2:0] ACT_PIN   = 3'd0;
	localparam logic [2:0] ACT_UNPIN = 3'd1;
	localparam logic [2:0] ACT_DIRTY = 3'd2;
	localparam logic [2:0] ACT_FORCE = 3'd3;
	localparam logic [2:0] ACT_FLUSH = 3'd4;

	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_RES    = 2'd1;
	localparam logic [1:0] ST_NEG_PAGE   = 2'd2;
	localparam logic [1:0] ST_ALL_PINNED = 2'd3;

	typedef struct packed {
		logic                 valid;
		logic [PAGE_BITS-1:0] page;
		logic                 dirty;
		logic [PIN_W-1:0]     pins;
		logic [STAMP_W-1:0]   stamp;
	} frame_entry_t;

	typedef struct packed {
		logic         en;
		frame_entry_t entry;
	} frame_wr_t;
endpackage

>>> hdl/bppr_req_if.sv
// Request channel of the buffer pool block: valid, ready and the request fields.
// Depends on nothing but its own signals.
`timescale 1ns / 1ps
interface bppr_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic signed [31:0] page_number;

	modport source (output valid, output action, output page_number, input ready);
	modport sink (input valid, input action, input page_number, output ready);
endinterface

>>> hdl/bppr_rsp_if.sv
// Result channel of the buffer pool block: valid, ready and the result fields.
// Depends on nothing but its own signals.
`timescale 1ns / 1ps
interface bppr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [3:0]  frame_index;
	logic [30:0] page_number_out;
	logic [15:0] fix_count;
	logic        was_hit;
	logic        last;
	logic [31:0] read_total;
	logic [31:0] write_total;

	modport source (output valid, output kind, output status, output frame_index,
		output page_number_out, output fix_count, output was_hit, output last,
		output read_total, output write_total, input ready);
	modport sink (input valid, input kind, input status, input frame_index,
		input page_number_out, input fix_count, input was_hit, input last,
		input read_total, input write_total, output ready);
endinterface

>>> hdl/bppr_frame_table.sv
// Frame table storage: one entry per frame, one shared read/write index.
// Depends on bppr_pkg.
`timescale 1ns / 1ps
module bppr_frame_table import bppr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  frame_wr_t        wr,
	output frame_entry_t     rd
);
	logic [FRAMES-1:0]    valid_q;
	logic [FRAMES-1:0]    dirty_q;
	logic [PIN_W-1:0]     pins_q  [FRAMES];
	logic [STAMP_W-1:0]   stamp_q [FRAMES];
	logic [PAGE_BITS-1:0] page_q  [FRAMES];

	assign rd.valid = valid_q[idx];
	assign rd.dirty = dirty_q[idx];
	assign rd.pins  = pins_q[idx];
	assign rd.stamp = stamp_q[idx];
	assign rd.page  = page_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				pins_q[i]  <= '0;
				stamp_q[i] <= '0;
			end
		end else if (wr.en) begin
			valid_q[idx] <= wr.entry.valid;
			dirty_q[idx] <= wr.entry.dirty;
			pins_q[idx]  <= wr.entry.pins;
			stamp_q[idx] <= wr.entry.stamp;
		end
	end

	// Page numbers are only looked at behind the valid bit, so they need no reset.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			page_q[idx] <= wr.entry.page;
		end
	end
endmodule

>>> hdl/buffer_pool_page_replacement.sv
// Operation: a request is taken in S_IDLE, then the sequencer walks the frames in use
// one per cycle; the flush sweep holds while a write-back waits for the output register.
// A CLOCK miss may sweep them twice, after any stale head or hand is brought below the frame count.
// Throughput: one request at a time; the next is taken once the completion is registered.
// Reset: asynchronous, active low; all frame state but the page numbers, counters and totals clear at once.
// Top level of the buffer pool frame table; depends on bppr_pkg, the two channel
// interfaces, bppr_frame_table and the assertion macro header.
`timescale 1ns / 1ps
`include "buffer_pool_page_replacement_defines.svh"
module buffer_pool_page_replacement import bppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bppr_req_if.sink              req,
	bppr_rsp_if.source            rsp
);
	// The sequencer owns a single frame index. Every step reads the entry at that index
	// through the frame table, and at most one entry is rewritten per cycle, so the
	// table behaves as a one-port store. The same read port serves the lookup, the
	// LRU minimum search and the FIFO and CLOCK sweeps.
	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_DECIDE, S_APPLY, S_HIT, S_NORM, S_VICT,
		S_VDONE, S_LOAD, S_FLUSH, S_DONE
	} state_t;

	state_t               state_q;
	logic [1:0]           policy_q;
	logic [CFG_DATA_W-1:0] frames_q;
	logic [2:0]           act_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 found_q;
	logic [IDX_W-1:0]     fidx_q;
	logic                 empty_q;
	logic [IDX_W-1:0]     eidx_q;
	logic                 anyfree_q;
	logic                 bestv_q;
	logic [IDX_W-1:0]     best_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic [IDX_W-1:0]     fifo_head_q;
	logic [IDX_W-1:0]     hand_q;
	logic [STAMP_W-1:0]   use_q;
	logic [TOTAL_W-1:0]   reads_q;
	logic [TOTAL_W-1:0]   writes_q;

	// Completion fields collected along the way, sent in S_DONE.
	logic [1:0]           cs_status_q;
	logic [IDX_W-1:0]     cs_frame_q;
	logic [PAGE_BITS-1:0] cs_page_q;
	logic [PIN_W-1:0]     cs_fix_q;
	logic                 cs_hit_q;

	// Output register.
	logic                 ovld_q;
	logic [1:0]           o_kind_q;
	logic [1:0]           o_status_q;
	logic [IDX_W-1:0]     o_frame_q;
	logic [PAGE_BITS-1:0] o_page_q;
	logic [PIN_W-1:0]     o_fix_q;
	logic                 o_hit_q;
	logic                 o_last_q;
	logic [TOTAL_W-1:0]   o_rd_q;
	logic [TOTAL_W-1:0]   o_wr_q;

	frame_entry_t e;
	frame_wr_t    wr;
	logic [N_W-1:0]   n;
	logic [IDX_W-1:0] n_last;
	logic [IDX_W-1:0] idx_nxt;
	logic [CNT_W-1:0] vlimit;
	logic             slot_free;
	logic             pol_lru;
	logic             pol_clock;
	logic             flush_hit;
	logic             load_out;

	bppr_frame_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx_q),
		.wr     (wr),
		.rd     (e)
	);

	// A frame count of zero acts as one, anything above the pool size as the pool size.
	always_comb begin
		if (frames_q == '0) begin
			n = N_W'(1);
		end else if (N_W'(frames_q) > N_W'(FRAMES)) begin
			n = N_W'(FRAMES);
		end else begin
			n = N_W'(frames_q);
		end
	end

	assign n_last    = IDX_W'(n - N_W'(1));
	assign idx_nxt   = (idx_q == n_last) ? '0 : idx_q + IDX_W'(1);
	assign pol_lru   = (policy_q == POL_LRU);
	assign pol_clock = (policy_q == POL_CLOCK);
	assign vlimit    = pol_clock ? {n, 1'b0} : CNT_W'(n);
	assign slot_free = !ovld_q || rsp.ready;
	assign flush_hit = e.valid && (e.pins == '0) && e.dirty;

	// High in every cycle in which the sequencer loads a transfer into the output register.
	assign load_out = slot_free && (((state_q == S_APPLY) && (act_q == ACT_FORCE)) ||
		((state_q == S_VDONE) && e.dirty) || (state_q == S_LOAD) ||
		((state_q == S_FLUSH) && flush_hit) || (state_q == S_DONE));

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid           = ovld_q;
	assign rsp.kind            = o_kind_q;
	assign rsp.status          = o_status_q;
	assign rsp.frame_index     = FRAME_OUT_W'(o_frame_q);
	assign rsp.page_number_out = PAGE_OUT_W'(o_page_q);
	assign rsp.fix_count       = o_fix_q;
	assign rsp.was_hit         = o_hit_q;
	assign rsp.last            = o_last_q;
	assign rsp.read_total      = o_rd_q;
	assign rsp.write_total     = o_wr_q;

	// Entry rewrite for the current step; wr.entry.pins also feeds the fix count.
	always_comb begin
		wr.en    = 1'b0;
		wr.entry = e;
		case (state_q)
			S_APPLY: begin
				if (act_q == ACT_UNPIN) begin
					wr.en = 1'b1;
					if (e.pins != '0) begin
						wr.entry.pins = e.pins - PIN_W'(1);
					end
				end else if (act_q == ACT_DIRTY) begin
					wr.en          = 1'b1;
					wr.entry.dirty = 1'b1;
				end else begin
					wr.en          = slot_free;
					wr.entry.dirty = 1'b0;
				end
			end
			S_HIT: begin
				wr.en = 1'b1;
				if (e.pins != '1) begin
					wr.entry.pins = e.pins + PIN_W'(1);
				end
				if (pol_lru) begin
					wr.entry.stamp = use_q + STAMP_W'(1);
				end else if (pol_clock) begin
					wr.entry.stamp = STAMP_W'(1);
				end
			end
			S_VICT: begin
				if (pol_clock && (e.pins == '0) && (e.stamp != '0)) begin
					wr.en          = 1'b1;
					wr.entry.stamp = '0;
				end
			end
			S_VDONE: begin
				wr.en          = e.dirty && slot_free;
				wr.entry.dirty = 1'b0;
			end
			S_LOAD: begin
				wr.en          = slot_free;
				wr.entry.valid = 1'b1;
				wr.entry.page  = page_q;
				wr.entry.dirty = 1'b0;
				wr.entry.pins  = PIN_W'(1);
				if (pol_lru) begin
					wr.entry.stamp = use_q + STAMP_W'(1);
				end else if (pol_clock) begin
					wr.entry.stamp = STAMP_W'(1);
				end
			end
			S_FLUSH: begin
				wr.en          = flush_hit && slot_free;
				wr.entry.dirty = 1'b0;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FIFO;
			frames_q     <= CFG_DATA_W'(FRAMES);
			fifo_head_q  <= '0;
			hand_q       <= '0;
			use_q        <= '0;
			reads_q      <= '0;
			writes_q     <= '0;
			ovld_q       <= 1'b0;
			act_q        <= '0;
			page_q       <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			fidx_q       <= '0;
			empty_q      <= 1'b0;
			eidx_q       <= '0;
			anyfree_q    <= 1'b0;
			bestv_q      <= 1'b0;
			best_q       <= '0;
			best_stamp_q <= '0;
			cs_status_q  <= ST_OK;
			cs_frame_q   <= '0;
			cs_page_q    <= '0;
			cs_fix_q     <= '0;
			cs_hit_q     <= 1'b0;
			o_kind_q     <= KIND_DONE;
			o_status_q   <= ST_OK;
			o_frame_q    <= '0;
			o_page_q     <= '0;
			o_fix_q      <= '0;
			o_hit_q      <= 1'b0;
			o_last_q     <= 1'b0;
			o_rd_q       <= '0;
			o_wr_q       <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_POLICY) begin
					policy_q <= cfg_data[1:0];
				end else begin
					frames_q <= cfg_data;
				end
			end
			// The output register is refilled in the same cycle its transfer leaves.
			if (load_out) begin
				ovld_q <= 1'b1;
			end else if (rsp.ready) begin
				ovld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q       <= req.action;
						page_q      <= req.page_number[PAGE_BITS-1:0];
						idx_q       <= '0;
						cnt_q       <= '0;
						found_q     <= 1'b0;
						empty_q     <= 1'b0;
						anyfree_q   <= 1'b0;
						bestv_q     <= 1'b0;
						cs_status_q <= ST_OK;
						cs_frame_q  <= '0;
						cs_page_q   <= '0;
						cs_fix_q    <= '0;
						cs_hit_q    <= 1'b0;
						if (req.action > ACT_FLUSH) begin
							state_q <= S_DONE;
						end else if (req.action == ACT_FLUSH) begin
							state_q <= S_FLUSH;
						end else if (req.page_number[31:PAGE_BITS] != '0) begin
							cs_status_q <= ST_NEG_PAGE;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				// One pass: page match, first empty frame, any unpinned, LRU minimum.
				S_LOOK: begin
					if (e.valid && (e.page == page_q) && !found_q) begin
						found_q <= 1'b1;
						fidx_q  <= idx_q;
					end
					if (!e.valid && !empty_q) begin
						empty_q <= 1'b1;
						eidx_q  <= idx_q;
					end
					if (e.pins == '0) begin
						anyfree_q <= 1'b1;
						if (!bestv_q || (e.stamp < best_stamp_q)) begin
							bestv_q      <= 1'b1;
							best_q       <= idx_q;
							best_stamp_q <= e.stamp;
						end
					end
					idx_q <= idx_nxt;
					if (idx_q == n_last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cs_page_q <= page_q;
					cnt_q     <= '0;
					if (found_q) begin
						idx_q   <= fidx_q;
						state_q <= (act_q == ACT_PIN) ? S_HIT : S_APPLY;
					end else if (act_q != ACT_PIN) begin
						cs_status_q <= ST_NOT_RES;
						state_q     <= S_DONE;
					end else if (empty_q) begin
						idx_q   <= eidx_q;
						state_q <= S_LOAD;
					end else if (!anyfree_q) begin
						cs_status_q <= ST_ALL_PINNED;
						state_q     <= S_DONE;
					end else if (pol_lru) begin
						idx_q   <= best_q;
						state_q <= S_VDONE;
					end else begin
						idx_q   <= pol_clock ? hand_q : fifo_head_q;
						state_q <= S_NORM;
					end
				end
				S_APPLY: begin
					cs_frame_q <= idx_q;
					cs_fix_q   <= wr.entry.pins;
					if (act_q != ACT_FORCE) begin
						state_q <= S_DONE;
					end else if (slot_free) begin
						writes_q   <= writes_q + TOTAL_W'(1);
						o_kind_q   <= KIND_WRITE;
						o_status_q <= ST_OK;
						o_frame_q  <= idx_q;
						o_page_q   <= e.page;
						o_fix_q    <= e.pins;
						o_hit_q    <= 1'b0;
						o_last_q   <= 1'b0;
						o_rd_q     <= reads_q;
						o_wr_q     <= writes_q + TOTAL_W'(1);
						state_q    <= S_DONE;
					end
				end
				S_HIT: begin
					use_q      <= use_q + STAMP_W'(1);
					cs_frame_q <= idx_q;
					cs_fix_q   <= wr.entry.pins;
					cs_hit_q   <= 1'b1;
					state_q    <= S_DONE;
				end
				// Bring a stale head or hand back below the frame count.
				S_NORM: begin
					if (N_W'(idx_q) >= n) begin
						idx_q <= IDX_W'(N_W'(idx_q) - n);
					end else begin
						state_q <= S_VICT;
					end
				end
				S_VICT: begin
					if ((e.pins == '0) && (!pol_clock || (e.stamp == '0))) begin
						if (pol_clock) begin
							hand_q <= idx_nxt;
						end else begin
							fifo_head_q <= idx_nxt;
						end
						state_q <= S_VDONE;
					end else begin
						idx_q <= idx_nxt;
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q + CNT_W'(1) == vlimit) begin
							cs_status_q <= ST_ALL_PINNED;
							state_q     <= S_DONE;
						end
					end
				end
				S_VDONE: begin
					if (!e.dirty) begin
						state_q <= S_LOAD;
					end else if (slot_free) begin
						writes_q   <= writes_q + TOTAL_W'(1);
						o_kind_q   <= KIND_WRITE;
						o_status_q <= ST_OK;
						o_frame_q  <= idx_q;
						o_page_q   <= e.page;
						o_fix_q    <= e.pins;
						o_hit_q    <= 1'b0;
						o_last_q   <= 1'b0;
						o_rd_q     <= reads_q;
						o_wr_q     <= writes_q + TOTAL_W'(1);
						state_q    <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (slot_free) begin
						use_q       <= use_q + STAMP_W'(1);
						reads_q     <= reads_q + TOTAL_W'(1);
						o_kind_q    <= KIND_READ;
						o_status_q  <= ST_OK;
						o_frame_q   <= idx_q;
						o_page_q    <= page_q;
						o_fix_q     <= PIN_W'(1);
						o_hit_q     <= 1'b0;
						o_last_q    <= 1'b0;
						o_rd_q      <= reads_q + TOTAL_W'(1);
						o_wr_q      <= writes_q;
						cs_frame_q  <= idx_q;
						cs_fix_q    <= PIN_W'(1);
						state_q     <= S_DONE;
					end
				end
				S_FLUSH: begin
					if (!flush_hit || slot_free) begin
						if (flush_hit) begin
							writes_q   <= writes_q + TOTAL_W'(1);
							o_kind_q   <= KIND_WRITE;
							o_status_q <= ST_OK;
							o_frame_q  <= idx_q;
							o_page_q   <= e.page;
							o_fix_q    <= e.pins;
							o_hit_q    <= 1'b0;
							o_last_q   <= 1'b0;
							o_rd_q     <= reads_q;
							o_wr_q     <= writes_q + TOTAL_W'(1);
						end
						idx_q <= idx_nxt;
						if (idx_q == n_last) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (slot_free) begin
						o_kind_q   <= KIND_DONE;
						o_status_q <= cs_status_q;
						o_frame_q  <= cs_frame_q;
						o_page_q   <= cs_page_q;
						o_fix_q    <= cs_fix_q;
						o_hit_q    <= cs_hit_q;
						o_last_q   <= 1'b1;
						o_rd_q     <= reads_q;
						o_wr_q     <= writes_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted request always starts the sequencer.
	`BPPR_ASSERT_NEXT(a_accept_starts, clk, arst_n, req.valid && req.ready, state_q != S_IDLE)
	// Only the completion transfer closes a request.
	`BPPR_ASSERT_NOW(a_last_is_done, clk, arst_n, rsp.valid && rsp.last, rsp.kind == KIND_DONE)
	// A victim sweep never runs past its bound.
	`BPPR_ASSERT_NOW(a_sweep_bound, clk, arst_n, state_q == S_VICT, cnt_q < vlimit)
	// A read transfer always carries a pin count of one.
	`BPPR_ASSERT_NOW(a_read_fix, clk, arst_n, rsp.valid && (rsp.kind == KIND_READ),
		rsp.fix_count == 16'd1)
endmodule

>>> dv/tb_buffer_pool_page_replacement.sv
// Self-checking testbench of the buffer pool frame table: directed and random requests
// under all policy codes and a set of frame counts, checked result by result against a local predictor.
// Depends on bppr_pkg, bppr_req_if, bppr_rsp_if and the buffer_pool_page_replacement RTL.
`timescale 1ns / 1ps

module tb_buffer_pool_page_replacement;
	import bppr_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [3:0]  frame;
		logic [30:0] page;
		logic [15:0] fix;
		logic        hit;
		logic        last;
		logic [31:0] reads;
		logic [31:0] writes;
	} pool_item_t;

	// The scoreboard keeps its own copy of the frame table. Every accepted request is
	// run through it and the items it should cause are queued in order.
	class pool_scoreboard;
		pool_item_t  pending_q[$];
		int          errors;
		logic [1:0]  policy;
		logic [4:0]  nframes;
		bit          fvalid[FRAMES];
		logic [30:0] fpage[FRAMES];
		bit          fdirty[FRAMES];
		int unsigned fpins[FRAMES];
		int unsigned fstamp[FRAMES];
		int unsigned fifo_head, use_ctr, hand, reads, writes;

		function new();
			errors = 0;
			policy = POL_FIFO;
			nframes = 5'd16;
			for (int i = 0; i < FRAMES; i++) begin
				fvalid[i] = 0;
				fpage[i] = '0;
				fdirty[i] = 0;
				fpins[i] = 0;
				fstamp[i] = 0;
			end
			fifo_head = 0;
			use_ctr = 0;
			hand = 0;
			reads = 0;
			writes = 0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_POLICY)
				policy = data[1:0];
			else
				nframes = data;
		endfunction

		function void push(logic [1:0] kind, logic [1:0] status, int unsigned frame,
				logic [30:0] page, int unsigned fix, bit hit, bit last);
			pool_item_t it;
			it.kind = kind;
			it.status = status;
			it.frame = frame[3:0];
			it.page = page;
			it.fix = fix[15:0];
			it.hit = hit;
			it.last = last;
			it.reads = reads;
			it.writes = writes;
			pending_q.push_back(it);
		endfunction

		function void write_back(int unsigned f);
			fdirty[f] = 0;
			writes++;
			push(KIND_WRITE, ST_OK, f, fpage[f], fpins[f], 0, 0);
		endfunction

		function int choose_victim(int unsigned n);
			int unsigned h, best;
			bit any;
			any = 0;
			best = 0;
			for (int unsigned i = 0; i < n; i++)
				if (fpins[i] == 0)
					any = 1;
			if (!any)
				return -1;
			if (policy == POL_LRU) begin
				any = 0;
				for (int unsigned i = 0; i < n; i++) begin
					if (fpins[i] != 0)
						continue;
					if (!any || fstamp[i] < fstamp[best])
						best = i;
					any = 1;
				end
				return best;
			end
			if (policy == POL_CLOCK) begin
				// Second-chance sweep: referenced unpinned frames lose their bit.
				h = hand % n;
				for (int unsigned i = 0; i < 2 * n; i++) begin
					if (fpins[h] == 0) begin
						if (fstamp[h] == 0) begin
							hand = (h + 1) % n;
							return h;
						end
						fstamp[h] = 0;
					end
					h = (h + 1) % n;
				end
				return -1;
			end
			// FIFO, and the unused policy code that behaves like it.
			h = fifo_head % n;
			for (int unsigned i = 0; i < n; i++) begin
				if (fpins[h] == 0) begin
					fifo_head = (h + 1) % n;
					return h;
				end
				h = (h + 1) % n;
			end
			return -1;
		endfunction

		function void note_request(logic [2:0] act, logic [31:0] raw);
			int unsigned n, f;
			int slot;
			logic [30:0] pg;
			n = (nframes < 1) ? 1 : (nframes > FRAMES) ? FRAMES : nframes;
			pg = raw[30:0];
			if (act > ACT_FLUSH) begin
				push(KIND_DONE, ST_OK, 0, '0, 0, 0, 1);
				return;
			end
			if (act == ACT_FLUSH) begin
				for (int unsigned i = 0; i < n; i++)
					if (fvalid[i] && fpins[i] == 0 && fdirty[i])
						write_back(i);
				push(KIND_DONE, ST_OK, 0, '0, 0, 0, 1);
				return;
			end
			if (raw[31]) begin
				push(KIND_DONE, ST_NEG_PAGE, 0, '0, 0, 0, 1);
				return;
			end
			slot = -1;
			for (int unsigned i = 0; i < n; i++)
				if (slot < 0 && fvalid[i] && fpage[i] == pg)
					slot = i;
			if (act != ACT_PIN) begin
				if (slot < 0) begin
					push(KIND_DONE, ST_NOT_RES, 0, pg, 0, 0, 1);
					return;
				end
				f = slot;
				if (act == ACT_UNPIN) begin
					if (fpins[f] != 0)
						fpins[f]--;
				end else if (act == ACT_DIRTY) begin
					fdirty[f] = 1;
				end else begin
					write_back(f);
				end
				push(KIND_DONE, ST_OK, f, pg, fpins[f], 0, 1);
				return;
			end
			if (slot >= 0) begin
				f = slot;
				if (fpins[f] < 16'hFFFF)
					fpins[f]++;
				use_ctr++;
				if (policy == POL_LRU)
					fstamp[f] = use_ctr;
				else if (policy == POL_CLOCK)
					fstamp[f] = 1;
				push(KIND_DONE, ST_OK, f, pg, fpins[f], 1, 1);
				return;
			end
			for (int unsigned i = 0; i < n; i++)
				if (slot < 0 && !fvalid[i])
					slot = i;
			if (slot < 0) begin
				slot = choose_victim(n);
				if (slot < 0) begin
					push(KIND_DONE, ST_ALL_PINNED, 0, pg, 0, 0, 1);
					return;
				end
				if (fdirty[slot])
					write_back(slot);
			end
			f = slot;
			fvalid[f] = 1;
			fpage[f] = pg;
			fdirty[f] = 0;
			fpins[f] = 1;
			use_ctr++;
			if (policy == POL_LRU)
				fstamp[f] = use_ctr;
			else if (policy == POL_CLOCK)
				fstamp[f] = 1;
			reads++;
			push(KIND_READ, ST_OK, f, pg, 1, 0, 0);
			push(KIND_DONE, ST_OK, f, pg, 1, 0, 1);
		endfunction

		function void check_result(pool_item_t got);
			pool_item_t want;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result kind=%0d page=%0d", got.kind, got.page);
				return;
			end
			want = pending_q.pop_front();
			if (got.kind !== want.kind || got.status !== want.status ||
					got.frame !== want.frame || got.page !== want.page ||
					got.fix !== want.fix || got.hit !== want.hit ||
					got.last !== want.last || got.reads !== want.reads ||
					got.writes !== want.writes) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch exp: k=%0d s=%0d f=%0d p=%0d fix=%0d h=%0d l=%0d r=%0d w=%0d",
						want.kind, want.status, want.frame, want.page, want.fix,
						want.hit, want.last, want.reads, want.writes);
					$display("         got: k=%0d s=%0d f=%0d p=%0d fix=%0d h=%0d l=%0d r=%0d w=%0d",
						got.kind, got.status, got.frame, got.page, got.fix,
						got.hit, got.last, got.reads, got.writes);
				end
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 4000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bppr_req_if req_ch();
	bppr_rsp_if rsp_ch();

	buffer_pool_page_replacement u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	pool_scoreboard sb = new();

	// Idle percentages of the two sides; the receiver can also be told to hold off.
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_request;
	int hold_off_left;
	int cycle_count;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Inputs are changed only at falling edges, so each rising edge sees settled values.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = '0;
		req_ch.page_number = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_request = 0;
		hold_off_left = 0;
		cycle_count = 0;
	end

	// Both sides are sampled at the rising edge; requests are noted before results so a
	// result that could appear in the same cycle still finds its expectation.
	always @(posedge clk) begin
		pool_item_t got;
		cycle_count <= cycle_count + 1;
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.action, req_ch.page_number);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.kind = rsp_ch.kind;
			got.status = rsp_ch.status;
			got.frame = rsp_ch.frame_index;
			got.page = rsp_ch.page_number_out;
			got.fix = rsp_ch.fix_count;
			got.hit = rsp_ch.was_hit;
			got.last = rsp_ch.last;
			got.reads = rsp_ch.read_total;
			got.writes = rsp_ch.write_total;
			sb.check_result(got);
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver decides its ready level at every falling edge. A hold-off keeps it low
	// for a long stretch so the block backs up and stops taking requests.
	always @(negedge clk) begin
		if (hold_off_request != 0) begin
			hold_off_left = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			rsp_ch.ready = 1'b0;
		end else begin
			rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// One request transfer, preceded by random idle cycles. Called at a falling edge and
	// returns at a falling edge.
	task automatic send_request(logic [2:0] act, logic [31:0] page);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.page_number = page;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.configure(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Every request ends in a completion, so once the queue is empty the block is idle;
	// the extra cycles only cover the sequencer returning to its idle state.
	task automatic wait_drained();
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	// Pages mostly come from a pool a little larger than the frame count, so hits,
	// misses and evictions all happen; the rest probe the range edges and the sign bit.
	function automatic logic [31:0] pick_page(int unsigned span);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 86)
			return $urandom_range(0, span);
		if (r < 90)
			return 32'h7FFF_FFFF - $urandom_range(0, 2);
		if (r < 95)
			return $urandom | 32'h8000_0000;
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_action();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return ACT_PIN;
		if (r < 68)
			return ACT_UNPIN;
		if (r < 82)
			return ACT_DIRTY;
		if (r < 91)
			return ACT_FORCE;
		if (r < 97)
			return ACT_FLUSH;
		return 3'($urandom_range(5, 7));
	endfunction

	initial begin
		int pol_list[9];
		int frm_list[9];
		int unsigned span;
		pol_list = '{0, 1, 2, 3, 2, 1, 0, 2, 1};
		frm_list = '{16, 4, 8, 3, 0, 31, 5, 16, 1};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset settings: range edges, every action, the rejected
		// pages, a page that is not resident, unknown actions and pin counts falling to zero.
		send_request(ACT_PIN, 32'd0);
		send_request(ACT_PIN, 32'h7FFF_FFFF);
		send_request(ACT_PIN, 32'hFFFF_FFFF);
		send_request(ACT_PIN, 32'h8000_0000);
		send_request(ACT_UNPIN, 32'd99);
		send_request(ACT_DIRTY, 32'd0);
		send_request(ACT_FORCE, 32'h7FFF_FFFF);
		send_request(ACT_FLUSH, 32'h8000_0000);
		send_request(ACT_UNPIN, 32'd0);
		send_request(ACT_UNPIN, 32'd0);
		send_request(ACT_FLUSH, 32'd0);
		send_request(3'd5, 32'd7);
		send_request(3'd6, 32'h5555_5555);
		send_request(3'd7, 32'hAAAA_AAAA);
		send_request(ACT_FORCE, 32'hFFFF_FFFB);
		send_request(ACT_DIRTY, 32'd0);
		wait_drained();

		// A single frame: a miss evicts the dirty unpinned page, then another miss finds
		// every frame pinned. Repeated pins of the resident page raise its count.
		write_register(CFG_FRAMES, 5'd1);
		send_request(ACT_PIN, 32'd3);
		send_request(ACT_PIN, 32'd4);
		for (int i = 0; i < 3; i++)
			send_request(ACT_PIN, 32'd3);
		send_request(ACT_UNPIN, 32'd3);
		wait_drained();

		// Random phases over policy and frame count, including the out-of-range codes.
		for (int ph = 0; ph < 9; ph++) begin
			write_register(CFG_POLICY, CFG_DATA_W'(pol_list[ph]));
			write_register(CFG_FRAMES, CFG_DATA_W'(frm_list[ph]));
			if (ph < 3) begin
				send_idle_pct = 27;
				recv_idle_pct = 82;
			end else if (ph < 6) begin
				send_idle_pct = 82;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 3 || ph == 7)
				hold_off_request = 400;
			span = (frm_list[ph] < 1) ? 4 : (frm_list[ph] > 16) ? 22 : frm_list[ph] + 6;
			for (int k = 0; k < 50; k++)
				send_request(pick_action(), pick_page(span));
			wait_drained();
		end

		if (sb.pending_q.size() != 0)
			sb.errors += sb.pending_q.size();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/bppr_pkg.sv
hdl/bppr_req_if.sv
hdl/bppr_rsp_if.sv
hdl/bppr_frame_table.sv
hdl/buffer_pool_page_replacement.sv
dv/tb_buffer_pool_page_replacement.sv
